@@ src/assert_macros.svh @@
// Assertion macros for the cache core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ src/dmwbc_pkg.sv @@
// Package: types, codes and defaults of the direct-mapped write-back cache core.
package dmwbc_pkg;
	localparam int unsigned DEF_CACHE_BYTES = 16384;
	localparam int unsigned DEF_LINE_BYTES = 64;
	localparam int unsigned DEF_MEMORY_BYTES = 65536;

	localparam logic [15:0] RST_MEM_READ_COST = 16'd100;
	localparam logic [15:0] RST_MEM_WRITE_COST = 16'd50;
	localparam logic [15:0] RST_CACHE_READ_COST = 16'd1;
	localparam logic [15:0] RST_CACHE_WRITE_COST = 16'd1;

	typedef enum logic [1:0] {
		REG_MEM_READ_COST = 2'd0,
		REG_MEM_WRITE_COST = 2'd1,
		REG_CACHE_READ_COST = 2'd2,
		REG_CACHE_WRITE_COST = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_READ = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_CLEAR_TIME = 2'd2,
		KIND_INVALIDATE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WB,
		ST_FILL,
		ST_ACCESS,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [31:0] elapsed_time;
		logic out_of_range;
		logic wrote_back;
		logic hit;
		logic [31:0] read_data;
	} result_t;
endpackage

@@ src/dmwbc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module dmwbc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ src/direct_mapped_writeback_cache_core.sv @@
// Top level: direct-mapped write-back write-allocate cache with internal backing memory.
// Usage:
//  s_* carries requests: tdata = kind[1:0], address[33:2], write_data[65:34].
//  m_* carries one result per request: read_data, hit, wrote_back, out_of_range,
//  elapsed_time, from bit 0 up.
//  cfg_* writes one 16-bit cost register per transfer; cfg_ready is always high.
//  After reset the backing memory is zeroed one word a cycle, all MEMORY_BYTES/4 words
//  (16384 at defaults), with s_tready low; cost registers reset to 100/50/1/1.
//  States per request, after the lookup:
//   clear, invalidate, out of range: straight to response
//   hit: access, then response
//   clean miss: line fill, access, response
//   dirty miss: write-back, line fill, access, response
//  One request is in flight at a time; the line fill and write-back stream
//  one word a cycle through the single read port of each memory.
//  A held result sits in the output register; a new request is taken while it
//  waits, but its own result stalls until m_tready takes the previous one.
module direct_mapped_writeback_cache_core
	import dmwbc_pkg::*;
#(
	parameter int unsigned CACHE_BYTES = DEF_CACHE_BYTES,
	parameter int unsigned LINE_BYTES = DEF_LINE_BYTES,
	parameter int unsigned MEMORY_BYTES = DEF_MEMORY_BYTES
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [71:0] s_tdata, // kind, address, write_data, zero pad
	output logic m_tvalid,
	input logic m_tready,
	output logic [71:0] m_tdata, // read_data, hit, wrote_back, out_of_range, elapsed_time, pad
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	localparam int unsigned NUM_LINES = CACHE_BYTES / LINE_BYTES;
	localparam int unsigned WPL = LINE_BYTES / 4;
	localparam int unsigned CACHE_WORDS = NUM_LINES * WPL;
	localparam int unsigned MEM_WORDS = MEMORY_BYTES / 4;
	localparam int unsigned IDX_SH = $clog2(NUM_LINES);
	localparam int unsigned WO_SH = $clog2(WPL);
	localparam int unsigned IDX_W = (NUM_LINES > 1) ? IDX_SH : 1;
	localparam int unsigned TAG_RAW = (MEMORY_BYTES > CACHE_BYTES) ?
		$clog2(MEMORY_BYTES / CACHE_BYTES) : 0;
	localparam int unsigned TAG_W = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int unsigned DATA_AW = (CACHE_WORDS > 1) ? $clog2(CACHE_WORDS) : 1;
	localparam int unsigned MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int unsigned CNT_W = $clog2(WPL + 1);
	localparam int unsigned CLR_W = $clog2(MEM_WORDS + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(WPL);

	state_t state_q, state_d;

	logic [15:0] mem_read_cost_q, mem_write_cost_q, cache_read_cost_q, cache_write_cost_q;
	logic [31:0] time_q;
	logic [NUM_LINES-1:0] valid_q, dirty_q;
	logic [CLR_W-1:0] clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] kind_q;
	logic [31:0] addr_q, wdata_q;
	logic hit_q, wb_q, oor_q;
	logic [TAG_W-1:0] vtag_q;
	logic wb_s1, fill_s1;
	logic [DATA_AW-1:0] fill_addr_s1;
	logic [MEM_AW-1:0] wb_addr_s1;
	logic out_v_q;
	result_t res_q;

	logic [31:0] line_no, in_line_no;
	logic [IDX_W-1:0] idx, in_idx;
	logic [TAG_W-1:0] tag, tag_rd;
	logic [DATA_AW-1:0] word, cnt_word, line_base;
	logic oor;
	logic accept, resp_fire;

	logic tag_we;
	logic data_we, data_re;
	logic [DATA_AW-1:0] data_waddr, data_raddr;
	logic [31:0] data_wdata, data_rd;
	logic bk_we, bk_re;
	logic [MEM_AW-1:0] bk_waddr, bk_raddr;
	logic [31:0] bk_wdata, bk_rd;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign resp_fire = (state_q == ST_RESP) && (!out_v_q || m_tready);
	assign m_tvalid = out_v_q;
	assign m_tdata = {5'd0, res_q};

	assign in_line_no = s_tdata[33:2] / LINE_BYTES;
	assign in_idx = IDX_W'(in_line_no % NUM_LINES);
	assign line_no = addr_q / LINE_BYTES;
	assign idx = IDX_W'(line_no % NUM_LINES);
	assign tag = TAG_W'(line_no / NUM_LINES);
	assign oor = (addr_q >= MEMORY_BYTES);
	assign line_base = DATA_AW'(idx) << WO_SH;
	assign word = DATA_AW'((addr_q >> 2) % WPL);
	assign cnt_word = DATA_AW'(cnt_q) & DATA_AW'(WPL - 1);

	dmwbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_LINES)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(idx), .wdata(tag),
		.re(accept), .raddr(in_idx), .rdata(tag_rd)
	);

	dmwbc_ram #(.WIDTH(32), .DEPTH(CACHE_WORDS)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
		.re(data_re), .raddr(data_raddr), .rdata(data_rd)
	);

	dmwbc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_backing_ram (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.re(bk_re), .raddr(bk_raddr), .rdata(bk_rd)
	);

	always_comb begin
		tag_we = (state_q == ST_FILL) && (cnt_q == CNT_END);
		data_we = fill_s1 || ((state_q == ST_ACCESS) && (kind_q == KIND_WRITE));
		data_waddr = fill_s1 ? fill_addr_s1 : (line_base | word);
		data_wdata = fill_s1 ? bk_rd : wdata_q;
		data_re = ((state_q == ST_WB) && (cnt_q != CNT_END)) ||
			((state_q == ST_ACCESS) && (kind_q == KIND_READ));
		data_raddr = (state_q == ST_WB) ? (line_base | cnt_word) : (line_base | word);
		bk_we = (state_q == ST_CLEAR) || wb_s1;
		bk_waddr = (state_q == ST_CLEAR) ? MEM_AW'(clr_q) : wb_addr_s1;
		bk_wdata = (state_q == ST_CLEAR) ? 32'd0 : data_rd;
		bk_re = (state_q == ST_FILL) && (cnt_q != CNT_END);
		bk_raddr = (MEM_AW'(line_no) << WO_SH) | MEM_AW'(cnt_word);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_W'(MEM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (kind_q == KIND_CLEAR_TIME || kind_q == KIND_INVALIDATE || oor) begin
					state_d = ST_RESP;
				end else if (valid_q[idx] && tag_rd == tag) begin
					state_d = ST_ACCESS;
				end else if (valid_q[idx] && dirty_q[idx]) begin
					state_d = ST_WB;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_WB: begin
				if (cnt_q == CNT_END) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (cnt_q == CNT_END) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: state_d = ST_RESP;
			ST_RESP: begin
				if (resp_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_read_cost_q <= RST_MEM_READ_COST;
			mem_write_cost_q <= RST_MEM_WRITE_COST;
			cache_read_cost_q <= RST_CACHE_READ_COST;
			cache_write_cost_q <= RST_CACHE_WRITE_COST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_MEM_READ_COST: mem_read_cost_q <= cfg_data;
				REG_MEM_WRITE_COST: mem_write_cost_q <= cfg_data;
				REG_CACHE_READ_COST: cache_read_cost_q <= cfg_data;
				REG_CACHE_WRITE_COST: cache_write_cost_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
			time_q <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			wb_s1 <= 1'b0;
			fill_s1 <= 1'b0;
			out_v_q <= 1'b0;
			hit_q <= 1'b0;
			wb_q <= 1'b0;
			oor_q <= 1'b0;
		end else begin
			wb_s1 <= (state_q == ST_WB) && (cnt_q != CNT_END);
			fill_s1 <= (state_q == ST_FILL) && (cnt_q != CNT_END);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (resp_fire) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					hit_q <= 1'b0;
					wb_q <= 1'b0;
					oor_q <= 1'b0;
					cnt_q <= '0;
				end
				ST_LOOKUP: begin
					if (kind_q == KIND_READ || kind_q == KIND_WRITE) begin
						if (oor) begin
							oor_q <= 1'b1;
						end else if (valid_q[idx] && tag_rd == tag) begin
							hit_q <= 1'b1;
						end else begin
							time_q <= time_q + 32'(mem_read_cost_q);
							wb_q <= valid_q[idx] && dirty_q[idx];
						end
					end
				end
				ST_WB: begin
					if (cnt_q == CNT_END) begin
						cnt_q <= '0;
						time_q <= time_q + 32'(mem_write_cost_q);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (cnt_q == CNT_END) begin
						valid_q[idx] <= 1'b1;
						dirty_q[idx] <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ACCESS: begin
					if (kind_q == KIND_READ) begin
						time_q <= time_q + 32'(cache_read_cost_q);
					end else begin
						time_q <= time_q + 32'(cache_write_cost_q);
						dirty_q[idx] <= 1'b1;
					end
				end
				ST_RESP: begin
					if (resp_fire) begin
						if (kind_q == KIND_CLEAR_TIME) begin
							time_q <= '0;
						end
						if (kind_q == KIND_INVALIDATE) begin
							valid_q <= '0;
							dirty_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tdata[1:0];
			addr_q <= s_tdata[33:2];
			wdata_q <= s_tdata[65:34];
		end
		if (state_q == ST_LOOKUP) begin
			vtag_q <= tag_rd;
		end
		wb_addr_s1 <= (MEM_AW'(vtag_q) << (IDX_SH + WO_SH)) |
			(MEM_AW'(idx) << WO_SH) | MEM_AW'(cnt_word);
		fill_addr_s1 <= line_base | cnt_word;
		if (resp_fire) begin
			res_q.read_data <= (kind_q == KIND_READ && !oor_q) ? data_rd : 32'd0;
			res_q.hit <= hit_q;
			res_q.wrote_back <= wb_q;
			res_q.out_of_range <= oor_q;
			res_q.elapsed_time <= (kind_q == KIND_CLEAR_TIME) ? 32'd0 : time_q;
		end
	end

`include "assert_macros.svh"

	`ASSERT_CLK(a_no_req_in_clear, clk, arst_n, (state_q == ST_CLEAR) |-> !s_tready, "request taken during memory clear")
	`ASSERT_CLK(a_oor_quiet, clk, arst_n, (m_tvalid && res_q.out_of_range) |-> (!res_q.hit && !res_q.wrote_back), "out of range result flags access")
	`ASSERT_CLK(a_wb_not_hit, clk, arst_n, m_tvalid |-> !(res_q.hit && res_q.wrote_back), "hit with write-back")
	`ASSERT_NEXT(a_fill_valid, clk, arst_n, (state_q == ST_FILL && cnt_q == CNT_END), (state_q == ST_ACCESS && valid_q[idx] && !dirty_q[idx]), "filled line not valid and clean")
endmodule

@@ dv/direct_mapped_writeback_cache_core_tb.sv @@
// Testbench of the direct-mapped write-back cache core: directed, backpressure, config and random tests.
`timescale 1ns / 100ps

module direct_mapped_writeback_cache_core_tb;
	import dmwbc_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 60000;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// cache predictor state
	logic line_ok [256];
	logic line_mod [256];
	logic [1:0] line_tg [256];
	logic [31:0] cached_word [4096];
	logic [31:0] mem_word [16384];
	logic [31:0] cost_total;
	logic [15:0] cost_mem_rd, cost_mem_wr, cost_cache_rd, cost_cache_wr;

	result_t expected_results[$];
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	bit no_gaps = 1'b0;
	bit hold_request = 1'b0;

	direct_mapped_writeback_cache_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic result_t cache_access(kind_t kind, logic [31:0] addr, logic [31:0] wd);
		result_t r;
		logic [9:0] line;
		logic [7:0] idx;
		logic [1:0] tg;
		logic [3:0] w;
		r = '0;
		line = addr[15:6];
		idx = line[7:0];
		tg = line[9:8];
		w = addr[5:2];
		if (kind == KIND_CLEAR_TIME) begin
			cost_total = '0;
		end else if (kind == KIND_INVALIDATE) begin
			for (int i = 0; i < 256; i++) begin
				line_ok[i] = 1'b0;
				line_mod[i] = 1'b0;
			end
		end else if (addr >= 32'd65536) begin
			r.out_of_range = 1'b1;
		end else begin
			if (line_ok[idx] && line_tg[idx] == tg) begin
				r.hit = 1'b1;
			end else begin
				cost_total += cost_mem_rd;
				if (line_ok[idx] && line_mod[idx]) begin
					for (int i = 0; i < 16; i++)
						mem_word[{line_tg[idx], idx, i[3:0]}] = cached_word[{idx, i[3:0]}];
					cost_total += cost_mem_wr;
					r.wrote_back = 1'b1;
				end
				for (int i = 0; i < 16; i++)
					cached_word[{idx, i[3:0]}] = mem_word[{line, i[3:0]}];
				line_ok[idx] = 1'b1;
				line_tg[idx] = tg;
				line_mod[idx] = 1'b0;
			end
			if (kind == KIND_READ) begin
				r.read_data = cached_word[{idx, w}];
				cost_total += cost_cache_rd;
			end else begin
				cached_word[{idx, w}] = wd;
				cost_total += cost_cache_wr;
				line_mod[idx] = 1'b1;
			end
		end
		r.elapsed_time = cost_total;
		return r;
	endfunction

	task automatic send_request(kind_t kind, logic [31:0] addr, logic [31:0] wd);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'b0, wd, addr, kind};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(cache_access(kind, addr, wd));
		@(negedge clk);
	endtask

	task automatic write_cost(cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MEM_READ_COST: cost_mem_rd = val;
			REG_MEM_WRITE_COST: cost_mem_wr = val;
			REG_CACHE_READ_COST: cost_cache_rd = val;
			default: cost_cache_wr = val;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_request();
		int unsigned pick;
		logic [31:0] addr;
		kind_t kind;
		pick = $urandom_range(0, 99);
		kind = pick < 46 ? KIND_READ : pick < 92 ? KIND_WRITE :
			pick < 96 ? KIND_CLEAR_TIME : KIND_INVALIDATE;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			addr = $urandom_range(32'hFFFF_FFFF, 32'd65536);
		else if (pick < 8)
			addr = $urandom;
		else if (pick < 80)
			addr = {16'b0, 2'($urandom), 5'b0, 3'($urandom_range(0, 7)), 6'($urandom)};
		else
			addr = {16'b0, 16'($urandom)};
		send_request(kind, addr, $urandom);
	endtask

	task automatic test_directed();
		send_request(KIND_READ, 32'h0, 32'h0);
		send_request(KIND_WRITE, 32'h3, 32'hFFFF_FFFF);
		send_request(KIND_READ, 32'h0, 32'h0);
		send_request(KIND_WRITE, 32'h4000, 32'hA5A5_5A5A);
		send_request(KIND_READ, 32'h1, 32'h0);
		send_request(KIND_WRITE, 32'hFFFC, 32'h1234_5678);
		send_request(KIND_READ, 32'hFFFF, 32'h0);
		send_request(KIND_READ, 32'h10000, 32'h0);
		send_request(KIND_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_WRITE, 32'h8000_0000, 32'h0);
		send_request(KIND_CLEAR_TIME, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_READ, 32'hC000, 32'h0);
		send_request(KIND_WRITE, 32'h8000, 32'h0F0F_F0F0);
		send_request(KIND_INVALIDATE, 32'h0, 32'h0);
		send_request(KIND_READ, 32'h8000, 32'h0);
		send_request(KIND_READ, 32'h4000, 32'h0);
		send_request(KIND_WRITE, 32'h003C, 32'h8000_0001);
		send_request(KIND_READ, 32'h003C, 32'h0);
		wait_idle();
	endtask

	task automatic test_cost_settings();
		logic [15:0] vals [3];
		vals = '{16'd0, 16'hFFFF, 16'($urandom)};
		for (int s = 0; s < 3; s++) begin
			for (int r = 0; r < 4; r++)
				write_cost(cfg_reg_t'(r), s == 2 ? 16'($urandom) : vals[s]);
			repeat (60) random_request();
			wait_idle();
		end
		write_cost(REG_MEM_READ_COST, RST_MEM_READ_COST);
		write_cost(REG_MEM_WRITE_COST, RST_MEM_WRITE_COST);
		write_cost(REG_CACHE_READ_COST, RST_CACHE_READ_COST);
		write_cost(REG_CACHE_WRITE_COST, RST_CACHE_WRITE_COST);
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		no_gaps = 1'b1;
		repeat (30) random_request();
		no_gaps = 1'b0;
		wait_idle();
	endtask

	task automatic test_random();
		for (int n = 0; n < 520; n++) begin
			if (n % 130 == 0) no_gaps = ~no_gaps;
			random_request();
		end
		no_gaps = 1'b0;
		wait_idle();
	endtask

	// result consumer with random stalls and one long stall for the backpressure test
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, m_tdata[66:0]);
					errors++;
				end else begin
					result_t exp_r;
					exp_r = expected_results.pop_front();
					if (m_tdata[66:0] !== exp_r) begin
						$display("%0t: mismatch expected rd=%h hit=%b wb=%b oor=%b t=%h",
							$time, exp_r.read_data, exp_r.hit, exp_r.wrote_back,
							exp_r.out_of_range, exp_r.elapsed_time);
						$display("%0t:          actual rd=%h hit=%b wb=%b oor=%b t=%h",
							$time, m_tdata[31:0], m_tdata[32], m_tdata[33],
							m_tdata[34], m_tdata[66:35]);
						errors++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < 256; i++) begin
			line_ok[i] = 1'b0;
			line_mod[i] = 1'b0;
			line_tg[i] = '0;
		end
		for (int i = 0; i < 4096; i++) cached_word[i] = '0;
		for (int i = 0; i < 16384; i++) mem_word[i] = '0;
		cost_total = '0;
		cost_mem_rd = RST_MEM_READ_COST;
		cost_mem_wr = RST_MEM_WRITE_COST;
		cost_cache_rd = RST_CACHE_READ_COST;
		cost_cache_wr = RST_CACHE_WRITE_COST;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_cost_settings();
		test_random();
		if (errors == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
